### design/length_prefixed_field_deframer_unit_assert.svh
// Assertion macros shared by the deframer checker.
`ifndef LENGTH_PREFIXED_FIELD_DEFRAMER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_FIELD_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LPFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LPFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lpfd_pkg.sv
// Shared types and constants of the length-prefixed field deframer.
package lpfd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned LEN_W       = 16;
    localparam int unsigned ACCUM_W     = 17;
    localparam int unsigned IDX_W       = 8;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned RES_DEPTH   = 4;
    localparam int unsigned RES_PTR_W   = $clog2(RES_DEPTH);
    localparam int unsigned RES_CNT_W   = $clog2(RES_DEPTH + 1);

    localparam logic [LEN_W-1:0]   MAX_LEN_RESET = 16'd999;
    localparam logic [ACCUM_W-1:0] ACCUM_SAT     = 17'd65536;
    localparam logic [IDX_W-1:0]   IDX_MAX       = 8'd255;

    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_CONTENT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd3;

    // Parser phase, one-hot.
    typedef enum logic [4:0] {
        PH_LEN     = 5'b00001,
        PH_CONTENT = 5'b00010,
        PH_TERM    = 5'b00100,
        PH_DONE    = 5'b01000,
        PH_ERROR   = 5'b10000
    } t_phase;

    // One result item.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  index;
        logic              last;
    } t_result;

endpackage

### design/lpfd_parser.sv
// Byte parser: message state and the up to two results of each input byte.
module lpfd_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  logic [lpfd_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_eom,
    input  logic                       i_cfg_wr_en,
    input  logic [lpfd_pkg::LEN_W-1:0] i_cfg_wr_data,
    output logic [1:0]                 o_count,
    output lpfd_pkg::t_result          o_res0,
    output lpfd_pkg::t_result          o_res1
);
    import lpfd_pkg::*;

    t_phase               r_phase, n_phase;
    logic [ACCUM_W-1:0]   r_accum, n_accum;
    logic                 r_saw_digit, n_saw_digit;
    logic [LEN_W-1:0]     r_bytes_left, n_bytes_left;
    logic [IDX_W-1:0]     r_field_count, n_field_count;
    logic [LEN_W-1:0]     r_max_len;

    logic                 is_digit;
    logic [ACCUM_W+3:0]   accum_mac;
    logic                 ok;
    t_result              verdict;

    assign is_digit  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    // accum * 10 + digit, as two shifts and adds.
    assign accum_mac = {1'b0, r_accum, 3'b000} + {3'b000, r_accum, 1'b0}
                     + {{ACCUM_W{1'b0}}, 4'(i_byte - CH_ZERO)};

    // Next state and results for the byte on the input.
    always_comb begin
        n_phase       = r_phase;
        n_accum       = r_accum;
        n_saw_digit   = r_saw_digit;
        n_bytes_left  = r_bytes_left;
        n_field_count = r_field_count;
        o_count       = 2'd0;
        o_res0        = '0;
        o_res1        = '0;
        ok            = 1'b0;
        verdict       = '0;

        unique case (r_phase)
            PH_LEN: begin
                if (is_digit) begin
                    n_accum     = (accum_mac > {4'b0000, ACCUM_SAT}) ? ACCUM_SAT
                                                                     : accum_mac[ACCUM_W-1:0];
                    n_saw_digit = 1'b1;
                end else if ((i_byte == CH_DOT) && r_saw_digit) begin
                    if (r_accum > {1'b0, r_max_len}) begin
                        n_phase = PH_ERROR;
                    end else begin
                        n_bytes_left = r_accum[LEN_W-1:0];
                        n_phase      = (r_accum[LEN_W-1:0] == '0) ? PH_TERM : PH_CONTENT;
                    end
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_CONTENT: begin
                o_res0       = '{kind: KIND_CONTENT, data: i_byte,
                                 index: r_field_count, last: 1'b0};
                o_count      = 2'd1;
                n_bytes_left = r_bytes_left - LEN_W'(1);
                if (r_bytes_left == LEN_W'(1)) begin
                    n_phase = PH_TERM;
                end
            end
            PH_TERM: begin
                if (i_byte == CH_COMMA) begin
                    o_res0  = '{kind: KIND_CLOSED, data: '0,
                                index: r_field_count, last: 1'b0};
                    o_count = 2'd1;
                    if (r_field_count != IDX_MAX) begin
                        n_field_count = r_field_count + IDX_W'(1);
                    end
                    n_phase     = PH_LEN;
                    n_accum     = '0;
                    n_saw_digit = 1'b0;
                end else if (i_byte == CH_SEMI) begin
                    o_res0  = '{kind: KIND_CLOSED, data: '0,
                                index: r_field_count, last: 1'b0};
                    o_count = 2'd1;
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase

        // The verdict follows any other result; the message state then clears.
        if (i_eom) begin
            ok      = (n_phase == PH_DONE) && (i_byte == CH_SEMI);
            verdict = '{kind: (ok ? KIND_ACCEPT : KIND_REJECT), data: '0,
                        index: n_field_count, last: 1'b1};
            if (o_count == 2'd0) begin
                o_res0 = verdict;
            end else begin
                o_res1 = verdict;
            end
            o_count       = o_count + 2'd1;
            n_phase       = PH_LEN;
            n_accum       = '0;
            n_saw_digit   = 1'b0;
            n_bytes_left  = '0;
            n_field_count = '0;
        end else if (o_count == 2'd1) begin
            o_res0.last = 1'b1;
        end
    end

    // Message state advances on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_LEN;
            r_accum       <= '0;
            r_saw_digit   <= 1'b0;
            r_bytes_left  <= '0;
            r_field_count <= '0;
        end else if (i_take) begin
            r_phase       <= n_phase;
            r_accum       <= n_accum;
            r_saw_digit   <= n_saw_digit;
            r_bytes_left  <= n_bytes_left;
            r_field_count <= n_field_count;
        end
    end

    // Field length limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

endmodule

### design/lpfd_result_queue.sv
// Result queue: takes up to two results a cycle and hands out one when read.
module lpfd_result_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_wr_count,
    input  lpfd_pkg::t_result i_res0,
    input  lpfd_pkg::t_result i_res1,
    input  logic              i_rd,
    output logic              o_valid,
    output logic              o_room,
    output lpfd_pkg::t_result o_res
);
    import lpfd_pkg::*;

    t_result               r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [RES_CNT_W-1:0]  r_count, n_count;
    logic                  rd_fire;

    assign o_valid = (r_count != '0);
    // Room for the worst case of two results from one byte.
    assign o_room  = (r_count <= RES_CNT_W'(RES_DEPTH - 2));
    assign o_res   = r_mem[r_rd_ptr];
    assign rd_fire = i_rd && o_valid;
    assign n_count = r_count + RES_CNT_W'(i_wr_count) - RES_CNT_W'(rd_fire);

    // Storage writes.
    always_ff @(posedge i_clk) begin
        if (i_wr_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res0;
        end
        if (i_wr_count == 2'd2) begin
            r_mem[r_wr_ptr + RES_PTR_W'(1)] <= i_res1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + RES_PTR_W'(i_wr_count);
            r_rd_ptr <= r_rd_ptr + RES_PTR_W'(rd_fire);
            r_count  <= n_count;
        end
    end

endmodule

### design/length_prefixed_field_deframer_unit.sv
// Length-prefixed field deframer top level.
// Input channel (i_valid/o_ready) carries one message byte per transaction,
// with i_end_of_message marking the last byte of a message. Output channel
// (o_valid/i_ready) carries result transactions: content bytes, field
// closures and one accept or reject verdict per message.
// One byte is accepted per cycle while o_ready is high; a byte can cause up
// to two results and the output drains one per cycle unless stalled, so
// throughput is one byte per cycle while bytes yield at most one result
// each. A four-entry result queue decouples the channels: o_ready stays
// high while two slots are free. When the receiver stalls the queue fills
// and o_ready drops; nothing is lost. The user must write the field length
// limit through i_cfg_wr_en/i_cfg_wr_data only while the block is idle, not
// enforced by the block. Synchronous reset (i_rst_n low) empties the queue,
// returns the parser to expecting length digits and the limit to 999.
module length_prefixed_field_deframer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lpfd_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                          i_end_of_message,
    input  logic                          i_cfg_wr_en,
    input  logic [lpfd_pkg::LEN_W-1:0]    i_cfg_wr_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lpfd_pkg::KIND_W-1:0]   o_out_kind,
    output logic [lpfd_pkg::BYTE_W-1:0]   o_out_byte,
    output logic [lpfd_pkg::IDX_W-1:0]    o_field_index,
    output logic                          o_last_of_run
);
    import lpfd_pkg::*;

    logic       take;
    logic [1:0] res_count;
    t_result    res0, res1, head;
    logic       room;

    // A byte is taken only when the queue can hold all of its results.
    assign o_ready = room;
    assign take    = i_valid && room;

    lpfd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_byte        (i_in_byte),
        .i_eom         (i_end_of_message),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_count       (res_count),
        .o_res0        (res0),
        .o_res1        (res1)
    );

    lpfd_result_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_count (take ? res_count : 2'd0),
        .i_res0     (res0),
        .i_res1     (res1),
        .i_rd       (i_ready),
        .o_valid    (o_valid),
        .o_room     (room),
        .o_res      (head)
    );

    // Result fields.
    assign o_out_kind    = head.kind;
    assign o_out_byte    = head.data;
    assign o_field_index = head.index;
    assign o_last_of_run = head.last;

endmodule

### design/lpfd_port_checker.sv
// Port-level checker for the deframer, bound to the top level.
`include "length_prefixed_field_deframer_unit_assert.svh"

module lpfd_port_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [lpfd_pkg::KIND_W-1:0] o_out_kind,
    input logic [lpfd_pkg::BYTE_W-1:0] o_out_byte,
    input logic                        o_last_of_run
);
    import lpfd_pkg::*;

    // A stalled result transaction holds.
    `LPFD_ASSERT_NEXT(a_out_hold, o_valid && !i_ready,
        o_valid && $stable(o_out_kind) && $stable(o_out_byte), "stalled result changed")

    // Only content results carry a byte.
    `LPFD_ASSERT_NOW(a_byte_zero, o_valid && (o_out_kind != KIND_CONTENT),
        o_out_byte == '0, "non-content result carries a byte")

    // A verdict is always the final result of its byte.
    `LPFD_ASSERT_NOW(a_verdict_last,
        o_valid && ((o_out_kind == KIND_ACCEPT) || (o_out_kind == KIND_REJECT)),
        o_last_of_run, "verdict not marked last")

endmodule

bind length_prefixed_field_deframer_unit lpfd_port_checker u_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_kind    (o_out_kind),
    .o_out_byte    (o_out_byte),
    .o_last_of_run (o_last_of_run)
);

### verif/length_prefixed_field_deframer_unit_tb.sv
// Self-checking testbench for the length-prefixed field deframer: random and directed byte streams.
module length_prefixed_field_deframer_unit_tb;
    import lpfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned PRINT_CAP    = 100;
    localparam int unsigned SETTLE_TICKS = 8;

    // One byte waiting to be offered on the input channel.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              eom;
    } t_msg_byte;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_valid          = 1'b0;
    logic                o_ready;
    logic [BYTE_W-1:0]   i_in_byte        = '0;
    logic                i_end_of_message = 1'b0;
    logic                i_cfg_wr_en      = 1'b0;
    logic [LEN_W-1:0]    i_cfg_wr_data    = '0;
    logic                o_valid;
    logic                i_ready          = 1'b0;
    logic [KIND_W-1:0]   o_out_kind;
    logic [BYTE_W-1:0]   o_out_byte;
    logic [IDX_W-1:0]    o_field_index;
    logic                o_last_of_run;

    // Stimulus backlog, pending results and bookkeeping.
    t_msg_byte   byte_backlog[$];
    t_result     results_due[$];
    t_msg_byte   next_up;
    t_result     seen;
    t_result     want;
    logic        byte_taken    = 1'b0;
    bit          calm          = 1'b0;
    int unsigned hold_asks     = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    int unsigned bytes_queued  = 0;

    // Shadow parser state.
    t_phase             parse_phase  = PH_LEN;
    logic [ACCUM_W-1:0] len_acc      = '0;
    logic               got_digit    = 1'b0;
    logic [LEN_W-1:0]   content_left = '0;
    logic [IDX_W-1:0]   field_no     = '0;
    logic [LEN_W-1:0]   limit_copy   = MAX_LEN_RESET;

    length_prefixed_field_deframer_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_in_byte        (i_in_byte),
        .i_end_of_message (i_end_of_message),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_kind       (o_out_kind),
        .o_out_byte       (o_out_byte),
        .o_field_index    (o_field_index),
        .o_last_of_run    (o_last_of_run)
    );

    // Clock generation.
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Count one mismatch and print it while under the print cap.
    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP) begin
            $display("[%0d] mismatch: %s", cycle_count, what);
        end
    endtask

    function automatic t_result make_result(input logic [KIND_W-1:0] kind,
                                            input logic [BYTE_W-1:0] data);
        return {kind, data, field_no, 1'b0};
    endfunction

    // Advance the shadow parser by one byte and queue the results it causes.
    task automatic deframe_byte(input logic [BYTE_W-1:0] b, input logic eom);
        t_result     run[$];
        int unsigned grown;
        bit          ok;
        case (parse_phase)
            PH_LEN: begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    grown = 32'(len_acc) * 10 + ({24'd0, b} - 32'(CH_ZERO));
                    len_acc = (grown > 32'(ACCUM_SAT)) ? ACCUM_SAT : grown[ACCUM_W-1:0];
                    got_digit = 1'b1;
                end else if (b == CH_DOT && got_digit) begin
                    if (len_acc > {1'b0, limit_copy}) begin
                        parse_phase = PH_ERROR;
                    end else begin
                        content_left = len_acc[LEN_W-1:0];
                        parse_phase = (content_left == 0) ? PH_TERM : PH_CONTENT;
                    end
                end else begin
                    parse_phase = PH_ERROR;
                end
            end
            PH_CONTENT: begin
                run.insert(run.size(), make_result(KIND_CONTENT, b));
                content_left = content_left - 1'b1;
                if (content_left == 0) parse_phase = PH_TERM;
            end
            PH_TERM: begin
                if (b == CH_COMMA) begin
                    run.insert(run.size(), make_result(KIND_CLOSED, '0));
                    if (field_no != IDX_MAX) field_no = field_no + 1'b1;
                    parse_phase = PH_LEN;
                    len_acc = '0;
                    got_digit = 1'b0;
                end else if (b == CH_SEMI) begin
                    run.insert(run.size(), make_result(KIND_CLOSED, '0));
                    parse_phase = PH_DONE;
                end else begin
                    parse_phase = PH_ERROR;
                end
            end
            PH_DONE: begin
            end
            default: parse_phase = PH_ERROR;
        endcase

        // The last byte of a message carries the verdict and clears the parser.
        if (eom) begin
            ok = (parse_phase == PH_DONE) && (b == CH_SEMI);
            run.insert(run.size(), make_result(ok ? KIND_ACCEPT : KIND_REJECT, '0));
            parse_phase = PH_LEN;
            len_acc = '0;
            got_digit = 1'b0;
            content_left = '0;
            field_no = '0;
        end

        if (run.size() != 0) run[run.size()-1].last = 1'b1;
        foreach (run[i]) results_due.insert(results_due.size(), run[i]);
    endtask

    // Input driver: new values at the falling edge, valid held until accepted.
    always @(negedge i_clk) begin
        if (!i_valid || byte_taken) begin
            if (byte_backlog.size() != 0 && (calm || $urandom_range(99) >= 29)) begin
                next_up = byte_backlog.pop_front();
                i_valid <= 1'b1;
                i_in_byte <= next_up.data;
                i_end_of_message <= next_up.eom;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_served != hold_asks) begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= 29);
        end
    end

    // Monitor: predict on every accepted byte, check every accepted result.
    always @(posedge i_clk) begin
        byte_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (i_valid && o_ready) deframe_byte(i_in_byte, i_end_of_message);
            if (o_valid && i_ready) begin
                seen = {o_out_kind, o_out_byte, o_field_index, o_last_of_run};
                if (results_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result kind %0d byte %02h index %0d",
                                            seen.kind, seen.data, seen.index));
                end else begin
                    want = results_due.pop_front();
                    if (seen.kind != want.kind)
                        flag_mismatch($sformatf("kind %0d, expected %0d",
                                                seen.kind, want.kind));
                    if (seen.data != want.data)
                        flag_mismatch($sformatf("byte %02h, expected %02h",
                                                seen.data, want.data));
                    if (seen.index != want.index)
                        flag_mismatch($sformatf("field index %0d, expected %0d",
                                                seen.index, want.index));
                    if (seen.last != want.last)
                        flag_mismatch($sformatf("last_of_run %0d, expected %0d",
                                                seen.last, want.last));
                end
            end
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] data, input logic eom);
        byte_backlog.insert(byte_backlog.size(), t_msg_byte'{data: data, eom: eom});
        bytes_queued++;
    endtask

    // Queue a text as one message; the last character ends it.
    task automatic push_text(input string s);
        for (int j = 0; j < s.len(); j++) push_byte(s[j], j == s.len() - 1);
    endtask

    function automatic logic [BYTE_W-1:0] content_pick();
        case ($urandom_range(7))
            0: return CH_COMMA;
            1: return CH_SEMI;
            2: return CH_DOT;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Declared field length: mostly small and legal, sometimes at or over the limit.
    function automatic int pick_length();
        int unsigned r;
        int unsigned cap;
        r = $urandom_range(99);
        cap = (limit_copy < 10) ? limit_copy : 10;
        if (r < 70) return $urandom_range(cap);
        if (r < 82) return int'(limit_copy) + 1;
        if (r < 88) return $urandom_range(99999999, 65537);
        if (limit_copy <= 40 || r == 99) return int'(limit_copy);
        return $urandom_range(40, 11);
    endfunction

    // Build one message; broken ones get a corrupted byte, a cut-off tail or an extra byte.
    task automatic queue_message(input int nfields, input bit broken, input bit zero_only);
        logic [BYTE_W-1:0] msg[$];
        string             digits;
        int                declared;
        int                body;
        int                cut;
        for (int k = 0; k < nfields; k++) begin
            declared = zero_only ? 0 : pick_length();
            digits = $sformatf("%0d", declared);
            if ($urandom_range(9) == 0) msg.insert(msg.size(), CH_ZERO);
            for (int j = 0; j < digits.len(); j++) msg.insert(msg.size(), digits[j]);
            msg.insert(msg.size(), CH_DOT);
            // Declared lengths over 64 get at most three bytes; the message then runs short.
            body = (declared <= 64) ? declared : $urandom_range(3);
            repeat (body) msg.insert(msg.size(), content_pick());
            msg.insert(msg.size(), (k == nfields - 1) ? CH_SEMI : CH_COMMA);
        end

        // Bytes after the closing semicolon, sometimes ending in another one.
        if (!broken && $urandom_range(6) == 0) begin
            repeat ($urandom_range(3, 1)) msg.insert(msg.size(), 8'($urandom_range(255)));
            if ($urandom_range(1) != 0) msg.insert(msg.size(), CH_SEMI);
        end

        if (broken) begin
            case ($urandom_range(2))
                0: msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
                1: begin
                    cut = $urandom_range(msg.size(), 1);
                    while (msg.size() > cut) void'(msg.pop_back());
                end
                default: msg.insert($urandom_range(msg.size() - 1), 8'($urandom_range(255)));
            endcase
        end

        foreach (msg[j]) push_byte(msg[j], j == msg.size() - 1);
    endtask

    // Pure noise of one to six random bytes.
    task automatic queue_noise();
        int n;
        n = $urandom_range(6, 1);
        for (int j = 0; j < n; j++) push_byte(8'($urandom_range(255)), j == n - 1);
    endtask

    // Wait until every byte is taken and every result has come, then let the pipe settle.
    task automatic drain();
        while (byte_backlog.size() != 0 || i_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LEN_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        limit_copy = value;
    endtask

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("length_prefixed_field_deframer_unit_tb: FAIL");
        $finish;
    end

    // Test sequence.
    initial begin
        int unsigned phase_limits[6];
        int unsigned target;
        phase_limits[0] = 0;
        phase_limits[1] = 3;
        phase_limits[2] = 65535;
        phase_limits[3] = 17;
        phase_limits[4] = $urandom_range(65535);
        phase_limits[5] = 999;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases under the reset limit.
        push_text("0.;");
        push_byte(8'h32, 1'b0);
        push_byte(CH_DOT, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_text(",1.;;");
        push_text(" ");
        push_text("+");
        push_text(".");
        push_text("1000.");
        push_text("0.x");
        push_text("0.;z");
        drain();

        // Random phases, each under its own limit.
        for (int p = 0; p < 6; p++) begin
            write_limit(phase_limits[p][LEN_W-1:0]);
            calm = (p == 1);
            if (p == 3) hold_asks++;
            target = bytes_queued + 150;
            if (p == 5) queue_message(260, 1'b0, 1'b1);
            while (bytes_queued < target) begin
                if ($urandom_range(19) == 0) queue_noise();
                else queue_message($urandom_range(4, 1), $urandom_range(3) == 0, 1'b0);
            end
            drain();
            calm = 1'b0;
        end

        if (mismatches == 0) begin
            $display("length_prefixed_field_deframer_unit_tb: PASS");
        end else begin
            $display("length_prefixed_field_deframer_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
